@@ design/ab565_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ab565_pkg: shared types and constants of the ARGB8888-over-RGB565 blender
// Stage payload structs, dither mode codes, register indexes and the bias
// and saturation constants of the blend arithmetic.
// ----------------------------------------------------------------------------
package ab565_pkg;

  typedef enum logic [1:0] {
    DM_CHECKER0 = 2'd0,
    DM_CHECKER1 = 2'd1,
    DM_ROUND    = 2'd2,
    DM_TRUNC    = 2'd3
  } dither_mode_e;

  // Configuration register indexes.
  localparam logic CfgGlobalAlpha = 1'b0;
  localparam logic CfgDitherMode  = 1'b1;

  localparam logic [7:0] AlphaOpaque   = 8'd255;
  localparam logic [7:0] GlobalAlphaRst = 8'd255;
  localparam logic [8:0] BlendOne      = 9'd256;
  localparam logic [7:0] BiasLo        = 8'd64;
  localparam logic [7:0] BiasHi        = 8'd192;
  localparam logic [7:0] BiasMid       = 8'd128;
  localparam logic [2:0] SBiasRbLo     = 3'd2;
  localparam logic [2:0] SBiasRbHi     = 3'd6;
  localparam logic [1:0] SBiasGLo      = 2'd1;
  localparam logic [1:0] SBiasGHi      = 2'd3;
  localparam logic [5:0] Max5          = 6'd31;
  localparam logic [6:0] Max6          = 7'd63;

  // After global alpha scaling, with the biases already chosen.
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [4:0] d_r;
    logic [5:0] d_g;
    logic [4:0] d_b;
    logic [7:0] dbias;
    logic [2:0] sbias_rb;
    logic [1:0] sbias_g;
  } scaled_t;

  // Source and destination terms of each channel, ready to be summed.
  typedef struct packed {
    logic [5:0] src_r;
    logic [6:0] src_g;
    logic [5:0] src_b;
    logic [4:0] dst_r;
    logic [5:0] dst_g;
    logic [4:0] dst_b;
  } terms_t;

endpackage
`default_nettype wire

@@ design/ab565_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ab565_in_if: input pixel stream
// Carries one source pixel, one destination pixel and the column parity.
// ----------------------------------------------------------------------------
interface ab565_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_pixel;
  logic [15:0] dest_pixel;
  logic        column_odd;

  modport source (output valid, output source_pixel, output dest_pixel,
                  output column_odd, input ready);
  modport sink   (input valid, input source_pixel, input dest_pixel,
                  input column_odd, output ready);
endinterface
`default_nettype wire

@@ design/ab565_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ab565_out_if: output pixel stream
// Carries one composited RGB565 pixel.
// ----------------------------------------------------------------------------
interface ab565_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] blended_pixel;

  modport source (output valid, output blended_pixel, input ready);
  modport sink   (input valid, input blended_pixel, output ready);
endinterface
`default_nettype wire

@@ design/argb8888_over_rgb565_blend.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// argb8888_over_rgb565_blend: premultiplied source-over blend into RGB565
// Three-stage pipeline: global alpha scaling, destination weighting, then
// channel sum with saturation and the output register.
//
//   Channel   Direction  Beat contents
//   in_ch     sink       source_pixel[31:0], dest_pixel[15:0], column_odd
//   out_ch    source     blended_pixel[15:0]
//   cfg_*     input      write enable, register index, 8-bit data
//
// An accepted beat passes the scale, weight and output registers in turn; one beat
// per cycle is sustained while out_ch is ready, as the three register stages each take a beat a cycle.
// Reset clears the stage valid bits and loads global_alpha 255, dither_mode 2.
// A stall on out_ch holds each full stage; empty stages still fill, and
// in_ch.ready falls only once all three stages hold a beat.
// ----------------------------------------------------------------------------
module argb8888_over_rgb565_blend
  import ab565_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  ab565_in_if.sink        in_ch,
  ab565_out_if.source     out_ch
);

  logic [7:0]   global_alpha_q;
  dither_mode_e dither_mode_q;

  logic    s1_valid, s1_ready, s2_valid, s2_ready;
  scaled_t s1_data;
  terms_t  s2_data;

  // The user must write the registers only while the pipeline is empty; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      global_alpha_q <= GlobalAlphaRst;
      dither_mode_q  <= DM_ROUND;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGlobalAlpha: global_alpha_q <= cfg_data_i;
        CfgDitherMode:  dither_mode_q  <= dither_mode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  ab565_scale u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .global_alpha_i (global_alpha_q),
    .dither_mode_i  (dither_mode_q),
    .valid_i        (in_ch.valid),
    .ready_o        (in_ch.ready),
    .source_pixel_i (in_ch.source_pixel),
    .dest_pixel_i   (in_ch.dest_pixel),
    .column_odd_i   (in_ch.column_odd),
    .valid_o        (s1_valid),
    .ready_i        (s1_ready),
    .data_o         (s1_data)
  );

  ab565_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  ab565_sat u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (out_ch.valid),
    .ready_i (out_ch.ready),
    .pixel_o (out_ch.blended_pixel)
  );

  // A taken output frees room all the way back to the input.
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output was taken");

  // The input only stalls when every stage is full.
  a_full_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |-> (out_ch.valid && s2_valid && s1_valid))
    else $error("input stalled with an empty stage");

  // An output beat can only appear from a beat held in the middle stage.
  a_out_from_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_ch.valid) |-> $past(s2_valid))
    else $error("output valid rose without a middle stage beat");

  // The middle stage only fills from a beat held in the first stage.
  a_mid_from_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s2_valid) |-> $past(s1_valid))
    else $error("middle stage filled without a first stage beat");

endmodule
`default_nettype wire

@@ design/ab565_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ab565_scale: first stage, global alpha scaling and bias selection
// Scales the four source channels by the global alpha, passing them unchanged
// at 255, and picks the dither biases, by column in the checkerboard modes.
// ----------------------------------------------------------------------------
module ab565_scale
  import ab565_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [7:0]   global_alpha_i,
  input  wire dither_mode_e dither_mode_i,
  input  wire logic         valid_i,
  output logic              ready_o,
  input  wire logic [31:0]  source_pixel_i,
  input  wire logic [15:0]  dest_pixel_i,
  input  wire logic         column_odd_i,
  output logic              valid_o,
  input  wire logic         ready_i,
  output scaled_t           data_o
);

  logic    valid_q;
  scaled_t data_d, data_q;
  logic [15:0] prod_a, prod_r, prod_g, prod_b;
  logic        lane;

  assign prod_a = 16'(source_pixel_i[31:24]) * 16'(global_alpha_i);
  assign prod_r = 16'(source_pixel_i[23:16]) * 16'(global_alpha_i);
  assign prod_g = 16'(source_pixel_i[15:8])  * 16'(global_alpha_i);
  assign prod_b = 16'(source_pixel_i[7:0])   * 16'(global_alpha_i);

  // Phase 1 inverts the checkerboard, so the lane is mode bit 0 xor parity.
  assign lane = dither_mode_i[0] ^ column_odd_i;

  always_comb begin
    if (global_alpha_i < AlphaOpaque) begin
      data_d.a = prod_a[15:8];
      data_d.r = prod_r[15:8];
      data_d.g = prod_g[15:8];
      data_d.b = prod_b[15:8];
    end else begin
      data_d.a = source_pixel_i[31:24];
      data_d.r = source_pixel_i[23:16];
      data_d.g = source_pixel_i[15:8];
      data_d.b = source_pixel_i[7:0];
    end
    data_d.d_r = dest_pixel_i[15:11];
    data_d.d_g = dest_pixel_i[10:5];
    data_d.d_b = dest_pixel_i[4:0];
    unique case (dither_mode_i)
      DM_CHECKER0, DM_CHECKER1: begin
        data_d.dbias    = lane ? BiasHi : BiasLo;
        data_d.sbias_rb = lane ? SBiasRbHi : SBiasRbLo;
        data_d.sbias_g  = lane ? SBiasGHi : SBiasGLo;
      end
      DM_ROUND: begin
        data_d.dbias    = BiasMid;
        data_d.sbias_rb = '0;
        data_d.sbias_g  = '0;
      end
      default: begin
        data_d.dbias    = '0;
        data_d.sbias_rb = '0;
        data_d.sbias_g  = '0;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

@@ design/ab565_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ab565_mul: second stage, destination weighting and source reduction
// Multiplies each destination channel by 256 minus alpha, adds the bias and
// drops eight bits; biases and shifts the source channels down to 6/7 bits.
// ----------------------------------------------------------------------------
module ab565_mul
  import ab565_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  output logic         ready_o,
  input  wire scaled_t data_i,
  output logic         valid_o,
  input  wire logic    ready_i,
  output terms_t       data_o
);

  logic        valid_q;
  terms_t      data_d, data_q;
  logic [8:0]  inv;
  logic [13:0] wr, wg, wb;
  logic [8:0]  sr, sg, sb;

  assign inv = BlendOne - {1'b0, data_i.a};

  assign wr = 14'(data_i.d_r) * 14'(inv) + 14'(data_i.dbias);
  assign wg = 14'(data_i.d_g) * 14'(inv) + 14'(data_i.dbias);
  assign wb = 14'(data_i.d_b) * 14'(inv) + 14'(data_i.dbias);

  assign sr = {1'b0, data_i.r} + 9'(data_i.sbias_rb);
  assign sg = {1'b0, data_i.g} + 9'(data_i.sbias_g);
  assign sb = {1'b0, data_i.b} + 9'(data_i.sbias_rb);

  // The weighted 5-bit channels stay below 8192, so bit 13 is always clear.
  always_comb begin
    data_d.dst_r = wr[12:8];
    data_d.dst_g = wg[13:8];
    data_d.dst_b = wb[12:8];
    data_d.src_r = sr[8:3];
    data_d.src_g = sg[8:2];
    data_d.src_b = sb[8:3];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

@@ design/ab565_sat.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ab565_sat: third stage, channel sum and saturation
// Adds source and destination terms, clamps each channel and packs RGB565
// into the output register.
// ----------------------------------------------------------------------------
module ab565_sat
  import ab565_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  output logic        ready_o,
  input  wire terms_t data_i,
  output logic        valid_o,
  input  wire logic   ready_i,
  output logic [15:0] pixel_o
);

  logic        valid_q;
  logic [15:0] pixel_d, pixel_q;
  logic [5:0]  sum_r, sum_b;
  logic [6:0]  sum_g;
  logic [4:0]  out_r, out_b;
  logic [5:0]  out_g;

  assign sum_r = data_i.src_r + 6'(data_i.dst_r);
  assign sum_g = data_i.src_g + 7'(data_i.dst_g);
  assign sum_b = data_i.src_b + 6'(data_i.dst_b);

  assign out_r = (sum_r > Max5) ? Max5[4:0] : sum_r[4:0];
  assign out_g = (sum_g > Max6) ? Max6[5:0] : sum_g[5:0];
  assign out_b = (sum_b > Max5) ? Max5[4:0] : sum_b[4:0];

  assign pixel_d = {out_r, out_g, out_b};

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pixel_q <= pixel_d;
    end
  end

  assign valid_o = valid_q;
  assign pixel_o = pixel_q;

endmodule
`default_nettype wire

@@ tb/sv/tb_argb8888_over_rgb565_blend.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_argb8888_over_rgb565_blend: self-checking bench of the RGB565 blender
// Streams source/destination pixel beats through the block under several
// register settings and handshake pressures. Each accepted beat is run
// through a local model of the blend, and every output beat is checked
// against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module tb_argb8888_over_rgb565_blend;
  import ab565_pkg::*;

  localparam int unsigned ClkPeriod     = 8;
  localparam int unsigned LatencyCycles = 3;
  localparam int unsigned RandomBlocks  = 10;
  localparam int unsigned BlockBeats    = 50;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_data_i;

  ab565_in_if  in_ch ();
  ab565_out_if out_ch ();

  argb8888_over_rgb565_blend uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Local copy of the block's registers, updated on every write.
  logic [7:0]   alpha_q;
  dither_mode_e mode_q;

  logic [15:0]  pixel_queue[$];
  int unsigned  mismatch_count;
  int unsigned  sender_idle_pct;
  int unsigned  receiver_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [7:0] scale_by_alpha(input logic [7:0] c);
    logic [15:0] prod;
    prod = {8'd0, c} * {8'd0, alpha_q};
    return prod[15:8];
  endfunction

  function automatic logic [6:0] mix_channel(input logic [7:0] s, input logic [2:0] sbias,
                                             input int unsigned sshift, input logic [5:0] d,
                                             input logic [8:0] inv, input logic [7:0] dbias,
                                             input logic [6:0] maxv);
    logic [8:0]  s_term;
    logic [15:0] d_term;
    logic [7:0]  sum;
    s_term = ({1'b0, s} + {6'd0, sbias}) >> sshift;
    d_term = ({10'd0, d} * {7'd0, inv} + {8'd0, dbias}) >> 8;
    sum    = s_term[7:0] + d_term[7:0];
    return (sum > {1'b0, maxv}) ? maxv : sum[6:0];
  endfunction

  function automatic logic [15:0] blend_predict(input logic [31:0] src, input logic [15:0] dst,
                                                input logic odd);
    logic [7:0] a, r, g, b;
    logic [7:0] dbias;
    logic [2:0] sb_rb;
    logic [1:0] sb_g;
    logic [8:0] inv;
    logic       lane;
    logic [6:0] o_r, o_g, o_b;
    {a, r, g, b} = src;
    if (alpha_q < AlphaOpaque) begin
      a = scale_by_alpha(a);
      r = scale_by_alpha(r);
      g = scale_by_alpha(g);
      b = scale_by_alpha(b);
    end
    dbias = 8'd0;
    sb_rb = 3'd0;
    sb_g  = 2'd0;
    if (mode_q == DM_CHECKER0 || mode_q == DM_CHECKER1) begin
      // Phase 1 swaps the lanes of the checkerboard.
      lane  = (mode_q == DM_CHECKER1) ^ odd;
      dbias = lane ? BiasHi : BiasLo;
      sb_rb = lane ? SBiasRbHi : SBiasRbLo;
      sb_g  = lane ? SBiasGHi : SBiasGLo;
    end else if (mode_q == DM_ROUND) begin
      dbias = BiasMid;
    end
    inv = BlendOne - {1'b0, a};
    o_r = mix_channel(r, sb_rb, 3, {1'b0, dst[15:11]}, inv, dbias, {1'b0, Max5});
    o_g = mix_channel(g, {1'b0, sb_g}, 2, dst[10:5], inv, dbias, Max6);
    o_b = mix_channel(b, sb_rb, 3, {1'b0, dst[4:0]}, inv, dbias, {1'b0, Max5});
    return {o_r[4:0], o_g[5:0], o_b[4:0]};
  endfunction

  // Output side: random backpressure and the result check.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    logic [15:0] want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pixel_queue.size() == 0) begin
        $error("blended_pixel: unexpected beat, actual %h", out_ch.blended_pixel);
        mismatch_count++;
      end else begin
        want = pixel_queue.pop_front();
        if (out_ch.blended_pixel !== want) begin
          $error("blended_pixel: expected %h, actual %h", want, out_ch.blended_pixel);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_pixel(input logic [31:0] src, input logic [15:0] dst, input logic odd);
    in_ch.valid        <= 1'b1;
    in_ch.source_pixel <= src;
    in_ch.dest_pixel   <= dst;
    in_ch.column_odd   <= odd;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pixel_queue.push_back(blend_predict(src, dst, odd));
    if ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // Stops the stream and waits until the pipeline is empty.
  task automatic drain_pipeline;
    in_ch.valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgGlobalAlpha) alpha_q = data;
    else mode_q = dither_mode_e'(data[1:0]);
    @(posedge clk_i);
  endtask

  task automatic set_mode(input dither_mode_e m);
    // Upper data bits are don't-care for the 2-bit register.
    write_reg(CfgDitherMode, {6'($urandom_range(63)), m});
  endtask

  task automatic test_reset_defaults;
    send_pixel(32'h0000_0000, 16'hFFFF, 1'b0);
    send_pixel(32'hFFFF_FFFF, 16'h0000, 1'b1);
    send_pixel(32'hFF00_0000, 16'hFFFF, 1'b0);
    // Color channels above alpha over a black destination.
    send_pixel(32'h00FF_FFFF, 16'h0000, 1'b1);
    drain_pipeline();
  endtask

  task automatic test_dither_modes;
    dither_mode_e m;
    m = DM_CHECKER0;
    do begin
      set_mode(m);
      send_pixel(32'h0000_0000, 16'hFFFF, 1'b0);
      send_pixel(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      send_pixel(32'h80FF_40C0, 16'hA5A5, 1'b0);
      send_pixel(32'h80FF_40C0, 16'hA5A5, 1'b1);
      drain_pipeline();
      m = m.next();
    end while (m != DM_CHECKER0);
  endtask

  task automatic test_global_alpha;
    set_mode(DM_CHECKER1);
    write_reg(CfgGlobalAlpha, 8'd0);
    send_pixel(32'hFFFF_FFFF, 16'h1234, 1'b0);
    drain_pipeline();
    write_reg(CfgGlobalAlpha, 8'd254);
    send_pixel(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    drain_pipeline();
    write_reg(CfgGlobalAlpha, 8'd1);
    send_pixel(32'hFF80_8080, 16'h0000, 1'b0);
    drain_pipeline();
  endtask

  task automatic test_random_stream;
    logic [7:0]  a;
    logic [31:0] src;
    int unsigned kind;
    for (int unsigned blk = 0; blk < RandomBlocks; blk++) begin
      case (blk % 4)
        0: begin
          sender_idle_pct = 0;  receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 46; receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;  receiver_stall_pct = 46;
        end
        default: begin
          sender_idle_pct = 13; receiver_stall_pct = 13;
        end
      endcase
      case (blk)
        0: write_reg(CfgGlobalAlpha, 8'd0);
        1: write_reg(CfgGlobalAlpha, 8'd255);
        2: write_reg(CfgGlobalAlpha, 8'd254);
        default: begin
          if ($urandom_range(2) == 0) write_reg(CfgGlobalAlpha, 8'd255);
          else write_reg(CfgGlobalAlpha, 8'($urandom_range(255)));
        end
      endcase
      set_mode(dither_mode_e'((blk + $urandom_range(1)) % 4));
      for (int unsigned n = 0; n < BlockBeats; n++) begin
        kind = $urandom_range(9);
        a    = 8'($urandom_range(255));
        if (kind <= 5) begin
          // Well-formed premultiplied pixel: colors never exceed alpha.
          src = {a, 8'($urandom_range(a)), 8'($urandom_range(a)), 8'($urandom_range(a))};
        end else if (kind == 6) begin
          src = {($urandom_range(1) != 0) ? 8'hFF : 8'h00, 24'($urandom())};
        end else begin
          src = $urandom();
        end
        send_pixel(src, 16'($urandom()), 1'($urandom_range(1)));
      end
      drain_pipeline();
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CfgGlobalAlpha;
    cfg_data_i         = 8'd0;
    in_ch.valid        = 1'b0;
    in_ch.source_pixel = 32'd0;
    in_ch.dest_pixel   = 16'd0;
    in_ch.column_odd   = 1'b0;
    alpha_q            = GlobalAlphaRst;
    mode_q             = DM_ROUND;
    mismatch_count     = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_dither_modes();
    test_global_alpha();
    test_random_stream();

    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
